/* hw/rtl/pvt_pkg.sv */
// pvt_pkg: shared types and constants for the pid value table
// item layouts, kind and status codes, sequencer states
// no dependencies
package pvt_pkg;

    localparam int PID_W     = 13;
    localparam int VAL_W     = 16;
    localparam int IDX_W     = 5;
    localparam int CNT_W     = 6;
    localparam int DEPTH_DEF = 32;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_LOOKUP = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [PID_W-1:0] pid;
        logic [VAL_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        status_t          status;
        logic             found;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] found_value;
        logic [CNT_W-1:0] count;
    } out_item_t;

    typedef struct packed {
        logic [PID_W-1:0] pid;
        logic [VAL_W-1:0] value;
    } entry_t;

endpackage

/* hw/rtl/pvt_mem.sv */
// pvt_mem: table storage, one write port and one registered read port
// entries hold an identifier and its value
// depends on pvt_pkg
module pvt_mem #(
    parameter int DEPTH = pvt_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  pvt_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output pvt_pkg::entry_t rd_data
);
    import pvt_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/pvt_seq.sv */
// pvt_seq: sequencer that scans the table with one shared compare
// and closes the gap after a remove, one entry a cycle
// depends on pvt_pkg; drives the ports of pvt_mem
module pvt_seq #(
    parameter int DEPTH = pvt_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pvt_pkg::in_item_t  s_data,
    input  logic               slot_free,
    output logic               done,
    output pvt_pkg::out_item_t result,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output pvt_pkg::entry_t    wr_data,
    output logic               rd_en,
    output logic [AW-1:0]      rd_addr,
    input  pvt_pkg::entry_t    rd_data
);
    import pvt_pkg::*;

    state_t           state_reg,   state_next;
    logic [CW-1:0]    count_reg,   count_next;
    in_item_t         item_reg,    item_next;
    logic [CW-1:0]    scan_reg,    scan_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]    pos_reg,     pos_next;
    logic [VAL_W-1:0] hold_reg,    hold_next;
    logic [CW-1:0]    src_reg,     src_next;
    logic [AW-1:0]    dst_reg,     dst_next;
    logic             sh_vld_reg,  sh_vld_next;
    out_item_t        res_reg,     res_next;

    logic hit;
    logic has_room;
    logic scan_more;
    logic src_more;

    assign hit       = cmp_vld_reg && (rd_data.pid == item_reg.pid);
    assign has_room  = count_reg < CW'(DEPTH);
    assign scan_more = scan_reg < count_reg;
    assign src_more  = src_reg < count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            sh_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
            sh_vld_reg  <= sh_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        scan_reg    <= scan_next;
        cmp_idx_reg <= cmp_idx_next;
        pos_reg     <= pos_next;
        hold_reg    <= hold_next;
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        res_reg     <= res_next;
    end

    // next state and working registers
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        item_next    = item_reg;
        scan_next    = scan_reg;
        cmp_vld_next = cmp_vld_reg;
        cmp_idx_next = cmp_idx_reg;
        pos_next     = pos_reg;
        hold_next    = hold_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        sh_vld_next  = sh_vld_reg;
        res_next     = res_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    res_next  = '{status: ST_OK, found: 1'b0, index: '0,
                                  found_value: '0, count: CNT_W'(count_reg)};
                    case (s_data.kind)
                        KIND_APPEND: begin
                            if (has_room) begin
                                count_next     = count_reg + CW'(1);
                                res_next.index = IDX_W'(count_reg[AW-1:0]);
                                res_next.count = CNT_W'(count_reg + CW'(1));
                            end else begin
                                res_next.status = ST_FULL;
                            end
                            state_next = S_DONE;
                        end
                        KIND_REMOVE, KIND_LOOKUP: begin
                            scan_next    = '0;
                            cmp_vld_next = 1'b0;
                            state_next   = S_SCAN;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // compare uses the registered read data, in the cycle after the read
                if (hit) begin
                    cmp_vld_next = 1'b0;
                    pos_next     = cmp_idx_reg;
                    hold_next    = rd_data.value;
                    if (item_reg.kind == KIND_REMOVE) begin
                        src_next    = CW'(cmp_idx_reg) + CW'(1);
                        dst_next    = cmp_idx_reg;
                        sh_vld_next = 1'b0;
                        state_next  = S_SHIFT;
                    end else begin
                        res_next   = '{status: ST_OK, found: 1'b1,
                                       index: IDX_W'(cmp_idx_reg),
                                       found_value: rd_data.value,
                                       count: CNT_W'(count_reg)};
                        state_next = S_DONE;
                    end
                end else if (scan_more) begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_reg[AW-1:0];
                    scan_next    = scan_reg + CW'(1);
                end else if (cmp_vld_reg) begin
                    cmp_vld_next = 1'b0;
                end else begin
                    res_next   = '{status: ST_ABSENT, found: 1'b0, index: '0,
                                   found_value: '0, count: CNT_W'(count_reg)};
                    state_next = S_DONE;
                end
            end
            S_SHIFT: begin
                // read entry src, write it one place down in the next cycle
                sh_vld_next = src_more;
                if (src_more) begin
                    src_next = src_reg + CW'(1);
                end
                if (sh_vld_reg) begin
                    dst_next = dst_reg + AW'(1);
                end
                if (!src_more && !sh_vld_reg) begin
                    count_next = count_reg - CW'(1);
                    res_next   = '{status: ST_OK, found: 1'b1,
                                   index: IDX_W'(pos_reg), found_value: hold_reg,
                                   count: CNT_W'(count_reg - CW'(1))};
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory control and handshake
    always_comb begin
        s_ready = 1'b0;
        done    = 1'b0;
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = '{pid: s_data.pid, value: s_data.value};
        rd_en   = 1'b0;
        rd_addr = scan_reg[AW-1:0];
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                wr_en   = s_valid && (s_data.kind == KIND_APPEND) && has_room;
            end
            S_SCAN: begin
                rd_en = !hit && scan_more;
            end
            S_SHIFT: begin
                rd_en   = src_more;
                rd_addr = src_reg[AW-1:0];
                wr_en   = sh_vld_reg;
                wr_addr = dst_reg;
                wr_data = rd_data;
            end
            S_DONE: begin
                done = slot_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign result = res_reg;

endmodule

/* hw/rtl/pid_value_table.sv */
// pid_value_table: ordered table of identifier and value pairs
// channel         | dir | handshake          | payload
// s_ (items in)   | in  | s_valid / s_ready  | in_item_t: kind, pid, value
// m_ (results)    | out | m_valid / m_ready  | out_item_t: status, found, index,
//                 |     |                    |   found_value, count
// append and unused kinds go from accept straight to the result, with no scan
// lookup and remove scan one entry a cycle through the single memory read port
//   and stop at the first hit; a miss scans every entry in the table;
//   remove then shifts each later entry one place down to close the gap
// aresetn empties the table at once; no clearing pass
// one item at a time; the result register lets a new item in while a result waits
module pid_value_table #(
    parameter int DEPTH = pvt_pkg::DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pvt_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pvt_pkg::out_item_t m_data
);
    import pvt_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;
    logic          done;
    out_item_t     result;
    logic          slot_free;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg,  m_data_next;

    pvt_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pvt_seq #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .slot_free (slot_free),
        .done      (done),
        .result    (result),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (done) begin
            m_valid_next = 1'b1;
            m_data_next  = result;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
